// ----- src/cdq_pkg.sv -----
// Shared constants and index wrap helpers for the circular double-ended queue unit.
// Depends on nothing; imported by the top level.
package cdq_pkg;

  localparam int DEPTH   = 16;
  localparam int ITEM_W  = 32;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REPORT     = 3'd4;

  localparam logic [STAT_W-1:0] STAT_SUCCESS   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    idx_next = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    idx_prev = (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

endpackage

// ----- src/cdq_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/circular_double_ended_queue_unit.sv -----
// Circular double-ended queue: top level with index control and two RAM copies.
// Depends on cdq_pkg and cdq_ram.
// An accepted beat goes through READ and CAPT before its result is registered.
// A new input beat is held off by in_stall until the write, read and capture
// steps through the registered read port of the slot memories are done.
// Reset: head 0, tail DEPTH-1, count 0, no result pending; slot contents are
// left as they are and are only used after a push has written them.
module circular_double_ended_queue_unit
  import cdq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [ITEM_W-1:0] in_push_item,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [CNT_W-1:0]  out_occupancy,
  output logic              out_ends_valid,
  output logic [ITEM_W-1:0] out_front_item,
  output logic [ITEM_W-1:0] out_rear_item
);

  // Sequencer: IDLE takes a beat and updates indices (writing a pushed item),
  // READ fetches the new front and rear slots, CAPT loads the output register.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CAPT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_ends_r;
  logic [ITEM_W-1:0] out_front_r;
  logic [ITEM_W-1:0] out_rear_r;

  logic              accept;
  logic              full;
  logic              empty;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              rd_en;
  logic              capture;
  logic [ITEM_W-1:0] front_data;
  logic [ITEM_W-1:0] rear_data;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign rd_en    = (state_r == ST_READ);

  // The output register may still hold the previous beat; capture waits
  // until it drains, and the RAM read registers hold their data meanwhile.
  assign capture  = (state_r == ST_CAPT) && (!out_valid_r || !out_stall);

  // Operation decode. Full pushes and empty pops leave the indices and count alone and only set an error status.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    stat_nxt  = stat_r;
    wr_en     = 1'b0;
    wr_addr   = idx_next(tail_r);
    if (accept) begin
      stat_nxt = STAT_SUCCESS;
      case (in_mode)
        MODE_PUSH_REAR: begin
          if (full) begin
            stat_nxt = STAT_OVERFLOW;
          end else begin
            tail_nxt  = idx_next(tail_r);
            count_nxt = count_r + 1'b1;
            wr_en     = 1'b1;
            wr_addr   = idx_next(tail_r);
          end
        end
        MODE_PUSH_FRONT: begin
          if (full) begin
            stat_nxt = STAT_OVERFLOW;
          end else begin
            head_nxt  = idx_prev(head_r);
            count_nxt = count_r + 1'b1;
            wr_en     = 1'b1;
            wr_addr   = idx_prev(head_r);
          end
        end
        MODE_POP_FRONT: begin
          if (empty) begin
            stat_nxt = STAT_UNDERFLOW;
          end else begin
            head_nxt  = idx_next(head_r);
            count_nxt = count_r - 1'b1;
          end
        end
        MODE_POP_REAR: begin
          if (empty) begin
            stat_nxt = STAT_UNDERFLOW;
          end else begin
            tail_nxt  = idx_prev(tail_r);
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          // Report only, and the unused codes behave the same way.
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_CAPT;
      end
      ST_CAPT: begin
        if (capture) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (capture) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= IDX_W'(DEPTH - 1);
      count_r     <= '0;
      stat_r      <= STAT_SUCCESS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      stat_r      <= stat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload. An empty queue reports zero for both end items.
  always_ff @(posedge clk) begin
    if (capture) begin
      out_status_r <= stat_r;
      out_count_r  <= count_r;
      out_ends_r   <= !empty;
      out_front_r  <= empty ? '0 : front_data;
      out_rear_r   <= empty ? '0 : rear_data;
    end
  end

  // Two copies of the slot store, written together, so that the front and
  // the rear slot can be read in the same cycle.
  cdq_ram #(
    .WIDTH(ITEM_W),
    .DEPTH(DEPTH)
  ) u_front_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_push_item),
    .rd_en   (rd_en),
    .rd_addr (head_r),
    .rd_data (front_data)
  );

  cdq_ram #(
    .WIDTH(ITEM_W),
    .DEPTH(DEPTH)
  ) u_rear_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_push_item),
    .rd_en   (rd_en),
    .rd_addr (tail_r),
    .rd_data (rear_data)
  );

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_occupancy  = out_count_r;
  assign out_ends_valid = out_ends_r;
  assign out_front_item = out_front_r;
  assign out_rear_item  = out_rear_r;

endmodule
